// ----- src/lge_pkg.sv -----
// ----------------------------------------------------------------------------
// lge_pkg
// shared types, codes and sizes of the life generation engine
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int unsigned ROWS = 64;
  localparam int unsigned COLS = 64;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned ROW_AW = $clog2(ROWS);
  localparam int unsigned CNT_W  = $clog2(ROWS + 2);
  localparam int unsigned GEN_W  = 32;
  localparam int unsigned NBR_W  = 4;

  localparam logic [WORD_W-1:0] COL_MASK = {WORD_W{1'b1}} >> (WORD_W - COLS);

  localparam logic [NBR_W-1:0] KEEP_CNT  = NBR_W'(2);
  localparam logic [NBR_W-1:0] BIRTH_CNT = NBR_W'(3);

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]        kind;
    logic [5:0]        row_index;
    logic [WORD_W-1:0] row_cells;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] cells_out;
    logic [GEN_W-1:0]  generation;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] addr;
  } mem_rd_t;

  // bit 0 is column c-1, bit 1 column c, bit 2 column c+1
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] here;
    logic [2:0] below;
  } nbr_t;

endpackage

// ----- src/life_generation_engine_unit.sv -----
// ----------------------------------------------------------------------------
// life_generation_engine_unit
// b3/s23 grid engine: row write, row read and one-generation advance
//
//   channel   | signals                           | moves
//   ----------+-----------------------------------+-------------------------
//   request   | in_valid_i in_ready_o in_req_i    | kind, row_index, row_cells
//   response  | out_valid_o out_ready_i out_rsp_o | cells_out, generation
//
// a write goes straight to the row memory; a read passes the memory read
// register and then its response register; an advance sweeps the row memory
// with a three-row window, one memory read and one memory write per row
// valid bits clear the grid at reset at once, no clearing pass
// a waiting response parks a read or advance in its emit cycle and holds
// the requests behind it
// ----------------------------------------------------------------------------
module life_generation_engine_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lge_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lge_pkg::rsp_t out_rsp_o
);
  import lge_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [GEN_W-1:0]  gen_q, gen_d;
  logic [WORD_W-1:0] win_a_q, win_a_d;
  logic [WORD_W-1:0] win_b_q, win_b_d;
  logic              is_read_q, is_read_d;
  logic              oor_q, oor_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q, out_rsp_d;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] below;
  logic [WORD_W-1:0] new_row;
  logic              in_fire;
  logic              in_range;
  logic              slot_free;
  logic              adv_last;

  lge_grid_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (mem_wr),
    .rd_i    (mem_rd),
    .rdata_o (rdata)
  );

  assign below = (cnt_q <= CNT_W'(ROWS)) ? rdata : '0;

  lge_row_lanes u_lanes (
    .above_i (win_a_q),
    .here_i  (win_b_q),
    .below_i (below),
    .row_o   (new_row)
  );

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_range  = {26'd0, in_req_i.row_index} < 32'(ROWS);
  assign slot_free = !out_valid_q || out_ready_i;
  assign adv_last  = (cnt_q == CNT_W'(ROWS + 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_req_i.kind == KIND_READ)) begin
          state_d = ST_EMIT;
        end else if (in_fire && (in_req_i.kind == KIND_ADVANCE)) begin
          state_d = ST_ADV;
        end
      end
      ST_ADV: begin
        if (adv_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    mem_wr      = '0;
    mem_rd      = '0;
    cnt_d       = cnt_q;
    gen_d       = gen_q;
    win_a_d     = win_a_q;
    win_b_d     = win_b_q;
    is_read_d   = is_read_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          case (in_req_i.kind)
            KIND_WRITE: begin
              mem_wr.en   = in_range;
              mem_wr.addr = ROW_AW'(in_req_i.row_index);
              mem_wr.data = in_req_i.row_cells & COL_MASK;
            end
            KIND_READ: begin
              mem_rd.en   = in_range;
              mem_rd.addr = ROW_AW'(in_req_i.row_index);
              is_read_d   = 1'b1;
              oor_d       = !in_range;
            end
            KIND_ADVANCE: begin
              is_read_d = 1'b0;
              oor_d     = 1'b0;
              cnt_d     = '0;
              win_a_d   = '0;
              win_b_d   = '0;
            end
            default: ;
          endcase
        end
      end
      ST_ADV: begin
        if (cnt_q < CNT_W'(ROWS)) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = ROW_AW'(cnt_q);
        end
        if (cnt_q >= CNT_W'(2)) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = ROW_AW'(cnt_q - CNT_W'(2));
          mem_wr.data = new_row;
        end
        if (cnt_q != '0) begin
          win_a_d = win_b_q;
          win_b_d = rdata;
        end
        cnt_d = cnt_q + CNT_W'(1);
        if (adv_last) begin
          gen_d = gen_q + GEN_W'(1);
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_rsp_d.cells_out  = (is_read_q && !oor_q) ? rdata : '0;
          out_rsp_d.generation = gen_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q     <= cnt_d;
    win_a_q   <= win_a_d;
    win_b_q   <= win_b_d;
    is_read_q <= is_read_d;
    oor_q     <= oor_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- src/lge_grid_mem.sv -----
// ----------------------------------------------------------------------------
// lge_grid_mem
// row memory of the grid, one write and one registered read port,
// per-row valid bits so that unwritten rows read as dead
// ----------------------------------------------------------------------------
module lge_grid_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lge_pkg::mem_wr_t             wr_i,
  input  lge_pkg::mem_rd_t             rd_i,
  output logic [lge_pkg::WORD_W-1:0]   rdata_o
);
  import lge_pkg::*;

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]   valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvld_q <= valid_q[rd_i.addr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- src/lge_cell_lane.sv -----
// ----------------------------------------------------------------------------
// lge_cell_lane
// one cell of the b3/s23 rule: neighbour count and survive/birth decision
// ----------------------------------------------------------------------------
module lge_cell_lane (
  input  lge_pkg::nbr_t nbr_i,
  output logic          alive_o
);
  import lge_pkg::*;

  logic [NBR_W-1:0] count;

  assign count = NBR_W'(nbr_i.above[0]) + NBR_W'(nbr_i.above[1]) + NBR_W'(nbr_i.above[2])
               + NBR_W'(nbr_i.here[0])  + NBR_W'(nbr_i.here[2])
               + NBR_W'(nbr_i.below[0]) + NBR_W'(nbr_i.below[1]) + NBR_W'(nbr_i.below[2]);

  assign alive_o = (count == BIRTH_CNT) || (nbr_i.here[1] && (count == KEEP_CNT));

endmodule

// ----- src/lge_row_lanes.sv -----
// ----------------------------------------------------------------------------
// lge_row_lanes
// one lane per column over a three-row window, merged into the new row word
// ----------------------------------------------------------------------------
module lge_row_lanes (
  input  logic [lge_pkg::WORD_W-1:0] above_i,
  input  logic [lge_pkg::WORD_W-1:0] here_i,
  input  logic [lge_pkg::WORD_W-1:0] below_i,
  output logic [lge_pkg::WORD_W-1:0] row_o
);
  import lge_pkg::*;

  logic [WORD_W-1:0] lane_out;

  for (genvar c = 0; c < WORD_W; c++) begin : g_lane
    if (c < COLS) begin : g_live
      nbr_t nbr;
      assign nbr.above[1] = above_i[c];
      assign nbr.here[1]  = here_i[c];
      assign nbr.below[1] = below_i[c];
      if (c > 0) begin : g_left
        assign nbr.above[0] = above_i[c-1];
        assign nbr.here[0]  = here_i[c-1];
        assign nbr.below[0] = below_i[c-1];
      end else begin : g_left_edge
        assign nbr.above[0] = 1'b0;
        assign nbr.here[0]  = 1'b0;
        assign nbr.below[0] = 1'b0;
      end
      if (c + 1 < COLS) begin : g_right
        assign nbr.above[2] = above_i[c+1];
        assign nbr.here[2]  = here_i[c+1];
        assign nbr.below[2] = below_i[c+1];
      end else begin : g_right_edge
        assign nbr.above[2] = 1'b0;
        assign nbr.here[2]  = 1'b0;
        assign nbr.below[2] = 1'b0;
      end
      lge_cell_lane u_lane (
        .nbr_i   (nbr),
        .alive_o (lane_out[c])
      );
    end else begin : g_off
      assign lane_out[c] = 1'b0;
    end
  end

  assign row_o = lane_out & COL_MASK;

endmodule
